/* src/irfpe_pkg.sv */
package irfpe_pkg;

   localparam int BUF_BYTES = 16;
   localparam int BUF_IDX_W = 4;
   localparam int BYTE_POS_W = 5;
   localparam int CODED_W = 24;
   localparam int CODED_CNT_W = 5;
   localparam int MARKER_W = 3;
   localparam int GAP_W = 16;
   localparam int FLEN_W = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [7:0] HEADER_PATTERN = 8'hF8;
   localparam logic [7:0] TAIL_PATTERN = 8'hF0;
   localparam logic [GAP_W-1:0] GAP_TICKS_RESET = 16'd30;

   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_WRITE_BYTE = 2'd1;
   localparam logic [1:0] KIND_LOAD_REPEATS = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TICKS = 1'd1;

   typedef struct packed {
      logic [1:0] kind;
      logic [BUF_IDX_W-1:0] index;
      logic [7:0] value;
   } item_type;

   typedef struct packed {
      logic led_on;
      logic frame_done;
      logic [7:0] repeats_left;
   } result_type;

   typedef struct packed {
      logic [FLEN_W-1:0] frame_length;
      logic [GAP_W-1:0] gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic [CODED_W-1:0] word;
      logic [CODED_CNT_W-1:0] count;
   } coded_type;

   // 1 -> 100, 0 -> 10, MSB first
   function automatic coded_type code_byte(input logic [7:0] b);
      coded_type c;
      c = '0;
      for (int k = 7; k >= 0; k--) begin
         if (b[k]) begin
            c.word = {c.word[CODED_W-4:0], 3'b100};
            c.count = c.count + CODED_CNT_W'(3);
         end else begin
            c.word = {c.word[CODED_W-3:0], 2'b10};
            c.count = c.count + CODED_CNT_W'(2);
         end
      end
      return c;
   endfunction

endpackage

/* src/irfpe_engine.sv */
module irfpe_engine
   import irfpe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   localparam logic [1:0] PHASE_HEADER = 2'd0;
   localparam logic [1:0] PHASE_DATA = 2'd1;
   localparam logic [1:0] PHASE_TAIL = 2'd2;

   logic [7:0] buf_ff [BUF_BYTES];
   logic [7:0] repeats_ff, repeats_in;
   logic [1:0] phase_ff, phase_in;
   logic in_gap_ff, in_gap_in;
   logic [MARKER_W-1:0] marker_ff, marker_in;
   logic [BYTE_POS_W-1:0] byte_pos_ff, byte_pos_in;
   logic [CODED_CNT_W-1:0] bits_pending_ff, bits_pending_in;
   logic [CODED_W-1:0] coded_ff, coded_in;
   logic [GAP_W-1:0] gap_count_ff, gap_count_in;
   logic led_ff, led_in;

   logic done;
   logic [BYTE_POS_W-1:0] len;
   logic [CODED_W-1:0] coded_shift;
   coded_type coded;

   assign len = (cfg.frame_length > BYTE_POS_W'(BUF_BYTES)) ? BYTE_POS_W'(BUF_BYTES)
                                                             : cfg.frame_length;
   assign coded = code_byte(buf_ff[byte_pos_ff[BUF_IDX_W-1:0]]);

   always_comb begin
      repeats_in = repeats_ff;
      phase_in = phase_ff;
      in_gap_in = in_gap_ff;
      marker_in = marker_ff;
      byte_pos_in = byte_pos_ff;
      bits_pending_in = bits_pending_ff;
      coded_in = coded_ff;
      gap_count_in = gap_count_ff;
      led_in = led_ff;
      done = 1'b0;
      coded_shift = '0;

      unique case (item.kind)
         KIND_TICK: begin
            if (in_gap_ff) begin
               led_in = 1'b0;
               if (gap_count_ff >= cfg.gap_ticks) begin
                  gap_count_in = '0;
                  in_gap_in = 1'b0;
               end else begin
                  gap_count_in = gap_count_ff + GAP_W'(1);
               end
            end else if (repeats_ff != 8'd0) begin
               unique case (phase_ff)
                  PHASE_HEADER: begin
                     led_in = HEADER_PATTERN[3'd7 - marker_ff];
                     marker_in = marker_ff + MARKER_W'(1);
                     if (marker_ff == 3'd7) begin
                        phase_in = PHASE_DATA;
                     end
                  end
                  PHASE_DATA: begin
                     if (bits_pending_ff == '0) begin
                        if (byte_pos_ff < len) begin
                           coded_in = coded.word;
                           bits_pending_in = coded.count;
                           byte_pos_in = byte_pos_ff + BYTE_POS_W'(1);
                        end else begin
                           // end of data: hold the LED for this tick
                           phase_in = PHASE_TAIL;
                        end
                     end
                     if (bits_pending_in != '0) begin
                        bits_pending_in = bits_pending_in - CODED_CNT_W'(1);
                        coded_shift = coded_in >> bits_pending_in;
                        led_in = coded_shift[0];
                     end
                  end
                  default: begin
                     led_in = TAIL_PATTERN[3'd7 - marker_ff];
                     marker_in = marker_ff + MARKER_W'(1);
                     if (marker_ff == 3'd7) begin
                        led_in = 1'b0;
                        repeats_in = repeats_ff - 8'd1;
                        phase_in = PHASE_HEADER;
                        byte_pos_in = '0;
                        done = 1'b1;
                        in_gap_in = 1'b1;
                        gap_count_in = '0;
                     end
                  end
               endcase
            end
         end
         KIND_LOAD_REPEATS: begin
            repeats_in = item.value;
         end
         default: begin
            // byte writes go straight to the buffer; kind 3 is dropped
         end
      endcase

      result.led_on = led_in;
      result.frame_done = done;
      result.repeats_left = repeats_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUF_BYTES; i++) begin
            buf_ff[i] <= '0;
         end
         repeats_ff <= '0;
         phase_ff <= PHASE_HEADER;
         in_gap_ff <= 1'b0;
         marker_ff <= '0;
         byte_pos_ff <= '0;
         bits_pending_ff <= '0;
         coded_ff <= '0;
         gap_count_ff <= '0;
         led_ff <= 1'b0;
      end else if (fire) begin
         // every 4-bit index lies inside the buffer
         if (item.kind == KIND_WRITE_BYTE) begin
            buf_ff[item.index] <= item.value;
         end
         repeats_ff <= repeats_in;
         phase_ff <= phase_in;
         in_gap_ff <= in_gap_in;
         marker_ff <= marker_in;
         byte_pos_ff <= byte_pos_in;
         bits_pending_ff <= bits_pending_in;
         coded_ff <= coded_in;
         gap_count_ff <= gap_count_in;
         led_ff <= led_in;
      end
   end

   a_gap_led_off: assert property (@(posedge clock) disable iff (reset)
      in_gap_ff |-> !led_ff)
      else $error("LED on during inter-frame gap");

   a_pending_in_data: assert property (@(posedge clock) disable iff (reset)
      (bits_pending_ff != '0) |-> (phase_ff == PHASE_DATA))
      else $error("coded bits pending outside data phase");

   a_done_enters_gap: assert property (@(posedge clock) disable iff (reset)
      (fire && result.frame_done) |=> (in_gap_ff && !led_ff && gap_count_ff == '0))
      else $error("frame end did not start a gap");

endmodule

/* src/ir_frame_pulse_encoder.sv */
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_kind, req_index, req_value
// rsp       out        rsp_valid/rsp_stall  rsp_led_on, rsp_frame_done, rsp_repeats_left
// csr       in         csr_we               csr_index, csr_wdata
//
// One transaction per cycle unless rsp_stall holds a result; results are registered.
// The step logic sits between the request register and the result register.
// Synchronous active-high reset clears engine state, the buffer and both valid flags.
// rsp_stall holds the result; the request register takes a transaction while it is empty,
// or while the result register is free or being taken in the same cycle.
module ir_frame_pulse_encoder
   import irfpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  logic [BUF_IDX_W-1:0]  req_index,
   input  logic [7:0]            req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_led_on,
   output logic                  rsp_frame_done,
   output logic [7:0]            rsp_repeats_left,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic s1_valid_ff, s1_valid_in;
   item_type s1_item_ff;
   logic rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, step_result;
   cfg_type cfg_ff;
   logic advance, fire, req_take;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign fire = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;

   assign s1_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && rsp_stall);

   irfpe_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (s1_item_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff.frame_length <= '0;
         cfg_ff.gap_ticks <= GAP_TICKS_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FRAME_LENGTH: cfg_ff.frame_length <= csr_wdata[FLEN_W-1:0];
               CSR_GAP_TICKS:    cfg_ff.gap_ticks <= csr_wdata[GAP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.kind <= req_kind;
         s1_item_ff.index <= req_index;
         s1_item_ff.value <= req_value;
      end
      if (fire) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_led_on = rsp_ff.led_on;
   assign rsp_frame_done = rsp_ff.frame_done;
   assign rsp_repeats_left = rsp_ff.repeats_left;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with room in the pipeline");

endmodule
